>>> src/pcc_pkg.sv
// Shared types, widths, register codes and defaults for the pivot correlation cluster.
package pcc_pkg;

   // Field widths fixed by the item formats.
   localparam int NODE_W      = 12;
   localparam int EDGE_W      = 32;
   localparam int NWEIGHT_W   = 31;
   localparam int COUNT_W     = 13;

   // Arithmetic widths: product of two weights, and the product of three weights against the shifted difference.
   localparam int PROD1_W     = 2 * NWEIGHT_W;
   localparam int CMP_W       = 93;

   // Defaults for the top level parameters.
   localparam int MAX_NODES_DEFAULT  = 4096;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // Configuration port.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [0:0] CSR_RESOLUTION    = 1'b0;
   localparam logic [0:0] CSR_WEIGHT_OFFSET = 1'b1;

   localparam logic [NWEIGHT_W-1:0] RESOLUTION_RESET    = 31'd65536;
   localparam logic [EDGE_W-1:0]    WEIGHT_OFFSET_RESET = 32'd0;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PROD,
      S_PIVOT,
      S_NEIGH,
      S_SUM,
      S_TEST,
      S_EMIT_P,
      S_EMIT_N
   } state_type;

endpackage

>>> src/pcc_req_if.sv
// Input channel carrying one edge item per transaction.
interface pcc_req_if;
   logic                             valid;
   logic                             ready;
   logic [pcc_pkg::NODE_W-1:0]       center;
   logic                             first_of_center;
   logic                             has_neighbor;
   logic [pcc_pkg::NODE_W-1:0]       neighbor;
   logic signed [pcc_pkg::EDGE_W-1:0] link_weight;
   logic [pcc_pkg::NWEIGHT_W-1:0]    center_weight;
   logic [pcc_pkg::NWEIGHT_W-1:0]    neighbor_weight;

   modport source (
      output valid, center, first_of_center, has_neighbor, neighbor,
             link_weight, center_weight, neighbor_weight,
      input  ready
   );

   modport sink (
      input  valid, center, first_of_center, has_neighbor, neighbor,
             link_weight, center_weight, neighbor_weight,
      output ready
   );
endinterface

>>> src/pcc_rsp_if.sv
// Result channel carrying one cluster assignment per transaction.
interface pcc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcc_pkg::NODE_W-1:0]  node;
   logic [pcc_pkg::NODE_W-1:0]  cluster_index;
   logic                        opens_cluster;
   logic                        last;

   modport source (
      output valid, node, cluster_index, opens_cluster, last,
      input  ready
   );

   modport sink (
      input  valid, node, cluster_index, opens_cluster, last,
      output ready
   );
endinterface

>>> src/pivot_correlation_cluster.sv
// Top level of the greedy pivot correlation clustering block.
//
//   Channel   Direction  Handshake              Contents
//   req_if    in         valid/ready            centre, neighbour ids, weights, flags
//   rsp_if    out        valid/ready            node, cluster index, opens, last
//   APB       in/out     psel/penable/pready    resolution, weight offset
//
// Each transaction steps through S_IDLE, S_PROD, S_PIVOT, S_NEIGH, S_SUM, S_TEST and an emit
// state per result, set by the one-port used-map read-modify-write and the two-step weight product.
// A result waits in the output register while the next transaction is taken.
// After reset the used map is cleared one entry a cycle with ready low.
// Reset is synchronous and active high; configuration writes are taken at any time.
module pivot_correlation_cluster #(
   parameter int MAX_NODES        = pcc_pkg::MAX_NODES_DEFAULT,
   parameter int WEIGHT_FRAC_BITS = pcc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   pcc_req_if.sink                           req_if,
   pcc_rsp_if.source                         rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pcc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pcc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pcc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int ADDR_W = $clog2(MAX_NODES);
   localparam int SHIFT  = 2 * WEIGHT_FRAC_BITS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_NODES - 1);

   // Control state.
   pcc_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [pcc_pkg::NWEIGHT_W-1:0] res_ff, res_in;
   logic [pcc_pkg::EDGE_W-1:0]    off_ff, off_in;
   logic                          active_ff, active_in;
   logic [pcc_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Item and datapath registers.
   logic [pcc_pkg::NODE_W-1:0]    center_ff, center_in;
   logic                          first_ff, first_in;
   logic                          has_nb_ff, has_nb_in;
   logic [pcc_pkg::NODE_W-1:0]    nb_ff, nb_in;
   logic [pcc_pkg::NWEIGHT_W-1:0] wc_ff, wc_in;
   logic [pcc_pkg::NWEIGHT_W-1:0] wn_ff, wn_in;
   logic [pcc_pkg::EDGE_W:0]      d_ff, d_in;
   logic [pcc_pkg::PROD1_W-1:0]   p_ff, p_in;
   logic [62:0]                   a_ff, a_in;
   logic [60:0]                   b_ff, b_in;
   logic [pcc_pkg::CMP_W-1:0]     r_ff, r_in;
   logic                          piv_emit_ff, piv_emit_in;
   logic [pcc_pkg::COUNT_W-1:0]   piv_idx_ff, piv_idx_in;
   logic                          fwd_ff, fwd_in;
   logic                          nb_used_ff, nb_used_in;
   logic                          join_ff, join_in;
   logic [pcc_pkg::NODE_W-1:0]    rsp_node_ff, rsp_node_in;
   logic [pcc_pkg::NODE_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                          rsp_opens_ff, rsp_opens_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Used-map port signals and helpers.
   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_waddr;
   logic [0:0]                    ram_wdata;
   logic [ADDR_W-1:0]             ram_raddr;
   logic [0:0]                    ram_rdata;
   logic                          accept;
   logic                          cfg_write;
   logic                          out_free;
   logic                          c_in_range;
   logic                          n_in_range;
   logic                          pivot_new;
   logic                          d_pos;
   logic [pcc_pkg::CMP_W-1:0]     d_shift;
   logic [pcc_pkg::COUNT_W-1:0]   nb_idx;

   pcc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NODES)
   ) u_used_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Handshakes and configuration port.
   assign accept    = req_if.valid && req_if.ready;
   assign cfg_write = psel && penable && pwrite;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign pready    = 1'b1;

   always_comb begin
      case (paddr[2])
         pcc_pkg::CSR_RESOLUTION:    prdata = {1'b0, res_ff};
         pcc_pkg::CSR_WEIGHT_OFFSET: prdata = off_ff;
         default:                    prdata = '0;
      endcase
   end

   // Range checks, join test operands and the neighbour's cluster number.
   assign c_in_range = 32'(center_ff) < 32'(MAX_NODES);
   assign n_in_range = 32'(nb_ff) < 32'(MAX_NODES);
   assign pivot_new  = first_ff && c_in_range && !ram_rdata[0];
   assign d_pos      = !d_ff[pcc_pkg::EDGE_W] && (d_ff != '0);
   assign d_shift    = pcc_pkg::CMP_W'(d_ff[pcc_pkg::EDGE_W-1:0]) << SHIFT;
   assign nb_idx     = count_ff - pcc_pkg::COUNT_W'(1);

   // Sequencer: next state, datapath next values and used-map accesses.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      res_in       = res_ff;
      off_in       = off_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      center_in    = center_ff;
      first_in     = first_ff;
      has_nb_in    = has_nb_ff;
      nb_in        = nb_ff;
      wc_in        = wc_ff;
      wn_in        = wn_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      piv_emit_in  = piv_emit_ff;
      piv_idx_in   = piv_idx_ff;
      fwd_in       = fwd_ff;
      nb_used_in   = nb_used_ff;
      join_in      = join_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_opens_in = rsp_opens_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = ADDR_W'(center_ff);
      ram_wdata    = 1'b1;
      ram_raddr    = ADDR_W'(center_ff);
      req_if.ready = 1'b0;

      // Register writes from the configuration port.
      if (cfg_write) begin
         case (paddr[2])
            pcc_pkg::CSR_RESOLUTION:    res_in = pwdata[pcc_pkg::NWEIGHT_W-1:0];
            pcc_pkg::CSR_WEIGHT_OFFSET: off_in = pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         pcc_pkg::S_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = 1'b0;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = pcc_pkg::S_IDLE;
            end
         end
         pcc_pkg::S_IDLE: begin
            req_if.ready = 1'b1;
            if (accept) begin
               center_in = req_if.center;
               first_in  = req_if.first_of_center;
               has_nb_in = req_if.has_neighbor;
               nb_in     = req_if.neighbor;
               wc_in     = req_if.center_weight;
               wn_in     = req_if.neighbor_weight;
               d_in      = {req_if.link_weight[pcc_pkg::EDGE_W-1], req_if.link_weight}
                         - {off_ff[pcc_pkg::EDGE_W-1], off_ff};
               state_in  = pcc_pkg::S_PROD;
            end
         end
         pcc_pkg::S_PROD: begin
            // Look up the centre while forming resolution times centre weight.
            ram_raddr = ADDR_W'(center_ff);
            p_in      = res_ff * wc_ff;
            state_in  = pcc_pkg::S_PIVOT;
         end
         pcc_pkg::S_PIVOT: begin
            // Decide on the pivot, mark it and look up the neighbour.
            piv_emit_in = pivot_new;
            piv_idx_in  = count_ff;
            if (first_ff) begin
               active_in = pivot_new;
            end
            if (pivot_new) begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(center_ff);
               count_in  = count_ff + pcc_pkg::COUNT_W'(1);
            end
            fwd_in    = pivot_new && (nb_ff == center_ff);
            ram_raddr = ADDR_W'(nb_ff);
            a_in      = p_ff[31:0] * wn_ff;
            state_in  = pcc_pkg::S_NEIGH;
         end
         pcc_pkg::S_NEIGH: begin
            // The centre written last cycle is forwarded in case the neighbour is the same node.
            nb_used_in = ram_rdata[0] || fwd_ff;
            b_in       = p_ff[pcc_pkg::PROD1_W-1:32] * wn_ff;
            state_in   = pcc_pkg::S_SUM;
         end
         pcc_pkg::S_SUM: begin
            r_in     = pcc_pkg::CMP_W'(a_ff) + (pcc_pkg::CMP_W'(b_ff) << 32);
            state_in = pcc_pkg::S_TEST;
         end
         pcc_pkg::S_TEST: begin
            join_in = has_nb_ff && active_ff && n_in_range && !nb_used_ff
                      && d_pos && (d_shift > r_ff);
            if (join_in) begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(nb_ff);
            end
            if (piv_emit_ff) begin
               state_in = pcc_pkg::S_EMIT_P;
            end else if (join_in) begin
               state_in = pcc_pkg::S_EMIT_N;
            end else begin
               state_in = pcc_pkg::S_IDLE;
            end
         end
         pcc_pkg::S_EMIT_P: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = center_ff;
               rsp_idx_in   = piv_idx_ff[pcc_pkg::NODE_W-1:0];
               rsp_opens_in = 1'b1;
               rsp_last_in  = !join_ff;
               state_in     = join_ff ? pcc_pkg::S_EMIT_N : pcc_pkg::S_IDLE;
            end
         end
         pcc_pkg::S_EMIT_N: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = nb_ff;
               rsp_idx_in   = nb_idx[pcc_pkg::NODE_W-1:0];
               rsp_opens_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = pcc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pcc_pkg::S_IDLE;
         end
      endcase
   end

   // State register and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcc_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         res_ff       <= pcc_pkg::RESOLUTION_RESET;
         off_ff       <= pcc_pkg::WEIGHT_OFFSET_RESET;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         res_ff       <= res_in;
         off_ff       <= off_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      center_ff    <= center_in;
      first_ff     <= first_in;
      has_nb_ff    <= has_nb_in;
      nb_ff        <= nb_in;
      wc_ff        <= wc_in;
      wn_ff        <= wn_in;
      d_ff         <= d_in;
      p_ff         <= p_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      r_ff         <= r_in;
      piv_emit_ff  <= piv_emit_in;
      piv_idx_ff   <= piv_idx_in;
      fwd_ff       <= fwd_in;
      nb_used_ff   <= nb_used_in;
      join_ff      <= join_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_opens_ff <= rsp_opens_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.node          = rsp_node_ff;
   assign rsp_if.cluster_index = rsp_idx_ff;
   assign rsp_if.opens_cluster = rsp_opens_ff;
   assign rsp_if.last          = rsp_last_ff;

   // The clearing pass runs once after reset and never again.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != pcc_pkg::S_CLEAR) |=> (state_ff != pcc_pkg::S_CLEAR))
      else $error("used map clearing pass restarted");

   // The cluster counter only advances when a pivot is decided.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == pcc_pkg::S_PIVOT))
      else $error("cluster counter moved outside pivot decision");

   // A pivot result carries the number of the cluster it just opened.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcc_pkg::S_EMIT_P) |-> (piv_idx_ff == nb_idx))
      else $error("pivot result index out of step with cluster counter");

   // A neighbour result is only produced after a successful join test.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcc_pkg::S_EMIT_N) |-> (join_ff && active_ff))
      else $error("neighbour result without a join");

   // A joining neighbour is always the last result of its transaction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_opens_ff) |-> rsp_last_ff)
      else $error("neighbour result not marked last");

endmodule

>>> src/pcc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pcc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = pcc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the pivot correlation cluster block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 10;
   localparam int Q_ONE           = 65536;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int DRAIN_CYCLES    = 24;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int HOLD_AFTER      = 200;
   localparam int HOLD_CYCLES     = 400;
   localparam int RECENT_DEPTH    = 48;

   // One edge item as the host streams it.
   typedef struct packed {
      logic [pcc_pkg::NODE_W-1:0]    center;
      logic                          first_of_center;
      logic                          has_neighbor;
      logic [pcc_pkg::NODE_W-1:0]    neighbor;
      logic [pcc_pkg::EDGE_W-1:0]    link_weight;
      logic [pcc_pkg::NWEIGHT_W-1:0] center_weight;
      logic [pcc_pkg::NWEIGHT_W-1:0] neighbor_weight;
   } edge_item_type;

   // One cluster assignment as the block reports it.
   typedef struct packed {
      logic [pcc_pkg::NODE_W-1:0] node;
      logic [pcc_pkg::NODE_W-1:0] cluster_index;
      logic                       opens_cluster;
      logic                       last;
   } cluster_result_type;

   // A directed row: typed_count below zero means the predictor decides.
   typedef struct {
      edge_item_type      item;
      int                 typed_count;
      cluster_result_type first_res;
      cluster_result_type second_res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [pcc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pcc_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pcc_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   pcc_req_if req_if();
   pcc_rsp_if rsp_if();

   pivot_correlation_cluster dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state: used nodes, the open pivot and the cluster numbering.
   bit                            node_used [4096];
   bit                            pivot_open;
   logic [pcc_pkg::COUNT_W-1:0]   cluster_total;
   logic [pcc_pkg::NWEIGHT_W-1:0] join_scale  = pcc_pkg::RESOLUTION_RESET;
   logic [pcc_pkg::EDGE_W-1:0]    join_offset = pcc_pkg::WEIGHT_OFFSET_RESET;

   cluster_result_type         pending_assignments[$];
   directed_row_type           directed_rows[$];
   logic [pcc_pkg::NODE_W-1:0] recent_nodes[$];

   int  mismatches       = 0;
   int  assignments_seen = 0;
   int  idle_cycles      = 0;
   bit  steady_tail      = 1'b0;
   bit  long_hold_done   = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // Exact join test: (edge - offset) * 2^(2F) against scale * wc * wn at full width.
   function automatic bit joins_cluster(input logic [pcc_pkg::EDGE_W-1:0] edge_w,
                                        input logic [pcc_pkg::NWEIGHT_W-1:0] wc,
                                        input logic [pcc_pkg::NWEIGHT_W-1:0] wn);
      logic signed [pcc_pkg::EDGE_W:0] margin;
      logic [127:0]                    lhs;
      logic [127:0]                    rhs;
      margin = $signed({edge_w[pcc_pkg::EDGE_W-1], edge_w})
             - $signed({join_offset[pcc_pkg::EDGE_W-1], join_offset});
      if (margin[pcc_pkg::EDGE_W] || margin == '0) begin
         return 1'b0;
      end
      lhs = 128'(margin[pcc_pkg::EDGE_W-1:0]) << (2 * pcc_pkg::FRAC_BITS_DEFAULT);
      rhs = 128'(join_scale) * 128'(wc) * 128'(wn);
      return lhs > rhs;
   endfunction

   // Works out the assignments one item causes and updates the predictor state.
   // Node ids are 12 bits wide, so every id lies below the node count of 4096.
   task automatic assign_clusters(input edge_item_type it, output int count,
                                  output cluster_result_type res_a,
                                  output cluster_result_type res_b);
      cluster_result_type          found[2];
      logic [pcc_pkg::COUNT_W-1:0] open_index;
      found[0] = '0;
      found[1] = '0;
      count    = 0;
      if (it.first_of_center) begin
         if (!node_used[it.center]) begin
            node_used[it.center] = 1'b1;
            pivot_open = 1'b1;
            found[count] = '{it.center, cluster_total[pcc_pkg::NODE_W-1:0], 1'b1, 1'b0};
            count++;
            cluster_total = cluster_total + 1'b1;
         end else begin
            pivot_open = 1'b0;
         end
      end
      if (it.has_neighbor && pivot_open && !node_used[it.neighbor]
          && joins_cluster(it.link_weight, it.center_weight, it.neighbor_weight)) begin
         node_used[it.neighbor] = 1'b1;
         open_index = cluster_total - 1'b1;
         found[count] = '{it.neighbor, open_index[pcc_pkg::NODE_W-1:0], 1'b0, 1'b0};
         count++;
      end
      if (count > 0) begin
         found[count - 1].last = 1'b1;
      end
      res_a = found[0];
      res_b = found[1];
   endtask

   function automatic edge_item_type edge_item(input int c, input int f, input int h,
                                               input int n, input logic [31:0] e,
                                               input logic [31:0] wc,
                                               input logic [31:0] wn);
      return '{pcc_pkg::NODE_W'(c), 1'(f), 1'(h), pcc_pkg::NODE_W'(n), e,
               pcc_pkg::NWEIGHT_W'(wc), pcc_pkg::NWEIGHT_W'(wn)};
   endfunction

   function automatic cluster_result_type assignment(input int node, input int idx,
                                                     input int opens, input int last);
      return '{pcc_pkg::NODE_W'(node), pcc_pkg::NODE_W'(idx), 1'(opens), 1'(last)};
   endfunction

   task automatic add_row(input edge_item_type it, input int count,
                          input cluster_result_type ra, input cluster_result_type rb);
      directed_row_type row;
      row = '{it, count, ra, rb};
      directed_rows = {directed_rows, row};
   endtask

   function automatic logic [pcc_pkg::NWEIGHT_W-1:0] pick_weight();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return '0;
      end
      if (sel == 1) begin
         return pcc_pkg::NWEIGHT_W'($urandom());
      end
      return pcc_pkg::NWEIGHT_W'($urandom_range(0, 2 * Q_ONE));
   endfunction

   function automatic logic [pcc_pkg::EDGE_W-1:0] pick_edge();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         return $urandom();
      end
      if (sel == 2) begin
         return pcc_pkg::EDGE_W'(Q_ONE + $urandom_range(0, 3)) - 32'd2;
      end
      return pcc_pkg::EDGE_W'($urandom_range(0, 5 * Q_ONE)) - pcc_pkg::EDGE_W'(2 * Q_ONE);
   endfunction

   function automatic logic [pcc_pkg::NODE_W-1:0] pick_neighbor(
      input logic [pcc_pkg::NODE_W-1:0] pivot);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2 && recent_nodes.size() > 0) begin
         return recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
      end
      if (sel == 2) begin
         return pivot;
      end
      return pcc_pkg::NODE_W'($urandom_range(0, 4095));
   endfunction

   function automatic void remember_node(input logic [pcc_pkg::NODE_W-1:0] id);
      recent_nodes = {recent_nodes, id};
      if (recent_nodes.size() > RECENT_DEPTH) begin
         void'(recent_nodes.pop_front());
      end
   endfunction

   // Offers one item from a falling edge, waits for the transaction, then maybe
   // leaves a gap. Returns just after a falling edge.
   task automatic send_item(input edge_item_type it, input int typed_count,
                            input cluster_result_type typed_a,
                            input cluster_result_type typed_b);
      int                 count;
      cluster_result_type res_a;
      cluster_result_type res_b;
      req_if.center          <= it.center;
      req_if.first_of_center <= it.first_of_center;
      req_if.has_neighbor    <= it.has_neighbor;
      req_if.neighbor        <= it.neighbor;
      req_if.link_weight     <= it.link_weight;
      req_if.center_weight   <= it.center_weight;
      req_if.neighbor_weight <= it.neighbor_weight;
      req_if.valid           <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      assign_clusters(it, count, res_a, res_b);
      if (typed_count >= 0) begin
         count = typed_count;
         res_a = typed_a;
         res_b = typed_b;
      end
      if (count > 0) begin
         pending_assignments = {pending_assignments, res_a};
      end
      if (count > 1) begin
         pending_assignments = {pending_assignments, res_b};
      end
      @(negedge clock);
      if (!steady_tail && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   // Waits until every expected assignment has come and the block has settled.
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (pending_assignments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write with setup and access cycles, then a read back of the value.
   task automatic write_csr(input logic [0:0] reg_idx,
                            input logic [pcc_pkg::CSR_DATA_W-1:0] value);
      logic [pcc_pkg::CSR_DATA_W-1:0] want;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_idx == pcc_pkg::CSR_RESOLUTION) begin
         join_scale = value[pcc_pkg::NWEIGHT_W-1:0];
      end else begin
         join_offset = value;
      end
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      want = (reg_idx == pcc_pkg::CSR_RESOLUTION) ? pcc_pkg::CSR_DATA_W'(join_scale)
                                                  : join_offset;
      if (prdata !== want) begin
         report_mismatch($sformatf("register %0d read %h want %h", reg_idx, prdata, want));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result side: compares each transaction with the oldest expectation.
   always @(posedge clock) begin
      cluster_result_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         assignments_seen++;
         if (pending_assignments.size() == 0) begin
            report_mismatch($sformatf("unexpected result for node %0d", rsp_if.node));
         end else begin
            want = pending_assignments.pop_front();
            if (rsp_if.node !== want.node) begin
               report_mismatch($sformatf("node %0d want %0d", rsp_if.node, want.node));
            end
            if (rsp_if.cluster_index !== want.cluster_index) begin
               report_mismatch($sformatf("cluster_index %0d want %0d (node %0d)",
                                         rsp_if.cluster_index, want.cluster_index, want.node));
            end
            if (rsp_if.opens_cluster !== want.opens_cluster) begin
               report_mismatch($sformatf("opens_cluster %b want %b (node %0d)",
                                         rsp_if.opens_cluster, want.opens_cluster, want.node));
            end
            if (rsp_if.last !== want.last) begin
               report_mismatch($sformatf("last %b want %b (node %0d)",
                                         rsp_if.last, want.last, want.node));
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result receiver: random stall bursts, calm stretches and one long hold-off.
   initial begin : result_receiver
      int stall_mode;
      int cycle_count;
      rsp_if.ready = 1'b0;
      stall_mode   = 0;
      cycle_count  = 0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 128 == 0) begin
            stall_mode = $urandom_range(0, 2);
         end
         if (!steady_tail && !long_hold_done && assignments_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!steady_tail && stall_mode != 0
                      && $urandom_range(0, (stall_mode == 1) ? 11 : 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed table, then random pivot streams per setting.
   initial begin : stimulus
      edge_item_type                  it;
      logic [pcc_pkg::NODE_W-1:0]     pivot;
      logic [pcc_pkg::NWEIGHT_W-1:0]  pivot_weight;
      logic [pcc_pkg::CSR_DATA_W-1:0] scale_val;
      logic [pcc_pkg::CSR_DATA_W-1:0] offset_val;
      int                             sent;
      int                             edges;
      cluster_result_type             none;

      none                   = '0;
      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      req_if.valid           = 1'b0;
      req_if.center          = '0;
      req_if.first_of_center = 1'b0;
      req_if.has_neighbor    = 1'b0;
      req_if.neighbor        = '0;
      req_if.link_weight     = '0;
      req_if.center_weight   = '0;
      req_if.neighbor_weight = '0;
      pivot_open             = 1'b0;
      cluster_total          = '0;

      // Directed table under the reset settings of scale 1.0 and offset 0.
      add_row(edge_item(0, 1, 0, 0, 0, 0, 0), 1, assignment(0, 0, 1, 1), none);
      add_row(edge_item(0, 0, 1, 4095, 32'h7FFF_FFFF, 0, 0), 1,
              assignment(4095, 0, 0, 1), none);
      // A pivot that is already used closes the open pivot and gives nothing.
      add_row(edge_item(4095, 1, 1, 5, 32'h7FFF_FFFF, 0, 0), 0, none, none);
      add_row(edge_item(0, 0, 1, 6, 32'h7FFF_FFFF, 0, 0), 0, none, none);
      // A neighbour equal to its pivot never joins.
      add_row(edge_item(100, 1, 1, 100, 32'h7FFF_FFFF, 0, 0), 1,
              assignment(100, 1, 1, 1), none);
      add_row(edge_item(100, 0, 1, 200, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
              0, none, none);
      add_row(edge_item(100, 0, 1, 200, 0, 0, 0), 0, none, none);
      add_row(edge_item(100, 0, 1, 200, 1, 0, 32'h7FFF_FFFF), 1,
              assignment(200, 1, 0, 1), none);
      add_row(edge_item(300, 1, 1, 301, 2 * Q_ONE, Q_ONE, Q_ONE), 2,
              assignment(300, 2, 1, 0), assignment(301, 2, 0, 1));
      // Exactly on the threshold does not join; one step above it does.
      add_row(edge_item(300, 0, 1, 302, Q_ONE, Q_ONE, Q_ONE), 0, none, none);
      add_row(edge_item(300, 0, 1, 303, Q_ONE + 1, Q_ONE, Q_ONE), 1,
              assignment(303, 2, 0, 1), none);
      add_row(edge_item(300, 0, 1, 301, 32'h7FFF_FFFF, 0, 0), 0, none, none);
      add_row(edge_item(301, 1, 0, 0, 0, 0, 0), 0, none, none);
      add_row(edge_item(301, 0, 1, 400, 32'h7FFF_FFFF, 0, 0), 0, none, none);
      add_row(edge_item(12'hAAA, 1, 1, 12'h555, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF), 1, assignment(12'hAAA, 3, 1, 1), none);
      add_row(edge_item(12'hAAA, 0, 0, 12'h555, 32'h7FFF_FFFF, 0, 0), 0, none, none);
      add_row(edge_item(12'hAAA, 0, 1, 12'h555, 32'h7FFF_FFFF, 32'h5555_5555,
                        32'h2AAA_AAAA), -1, none, none);
      add_row(edge_item(12'h555, 1, 1, 12'hAAA, 3 * Q_ONE, Q_ONE, 0), -1, none, none);
      add_row(edge_item(2048, 1, 1, 2047, 32'hFFFF_0000, 0, 0), -1, none, none);
      add_row(edge_item(2048, 0, 1, 1, 1, 32'h7FFF_FFFF, 1), -1, none, none);
      add_row(edge_item(2048, 0, 1, 2, 32'hFFFF_FFFF, 0, 0), -1, none, none);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed_count,
                   directed_rows[i].first_res, directed_rows[i].second_res);
      end

      // Random pivot streams, one register setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_block();
         case (phase)
            0: begin
               scale_val  = Q_ONE;
               offset_val = '0;
            end
            1: begin
               scale_val  = '0;
               offset_val = 32'h8000_0000;
            end
            2: begin
               scale_val  = 32'h7FFF_FFFF;
               offset_val = '0;
            end
            3: begin
               scale_val  = 1;
               offset_val = 32'h7FFF_FFFF;
            end
            default: begin
               scale_val  = $urandom_range(0, 4 * Q_ONE);
               offset_val = pcc_pkg::CSR_DATA_W'($urandom_range(0, 2 * Q_ONE))
                          - pcc_pkg::CSR_DATA_W'(Q_ONE);
            end
         endcase
         write_csr(pcc_pkg::CSR_RESOLUTION, scale_val);
         write_csr(pcc_pkg::CSR_WEIGHT_OFFSET, offset_val);
         steady_tail = (phase == PHASES - 1);

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               // Noise: any field combination, in or out of a pivot stream.
               it = edge_item($urandom_range(0, 4095), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 4095),
                              $urandom(), $urandom(), $urandom());
               send_item(it, -1, none, none);
               sent++;
            end else begin
               if ($urandom_range(0, 3) == 0 && recent_nodes.size() > 0) begin
                  pivot = recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
               end else begin
                  pivot = pcc_pkg::NODE_W'($urandom_range(0, 4095));
               end
               pivot_weight = pick_weight();
               edges = $urandom_range(0, 5);
               if (edges == 0) begin
                  it = edge_item(int'(pivot), 1, 0, $urandom_range(0, 4095), pick_edge(),
                                 32'(pivot_weight), 32'(pick_weight()));
                  send_item(it, -1, none, none);
                  sent++;
               end
               for (int k = 0; k < edges; k++) begin
                  it = edge_item(int'(pivot), (k == 0) ? 1 : 0, 1,
                                 int'(pick_neighbor(pivot)), pick_edge(),
                                 ($urandom_range(0, 9) == 0) ? 32'(pick_weight())
                                                             : 32'(pivot_weight),
                                 32'(pick_weight()));
                  send_item(it, -1, none, none);
                  remember_node(it.neighbor);
                  sent++;
               end
               remember_node(pivot);
            end
         end
      end

      drain_block();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
src/pcc_pkg.sv
src/pcc_req_if.sv
src/pcc_rsp_if.sv
src/pcc_ram.sv
src/pivot_correlation_cluster.sv
verif/tb.sv
